[sv/bbc_pkg.sv]
// Shared types and codes for the block buffer cache.
// Holds the request, status and sequencer enums and the slot entry layout.
`timescale 1ns / 1ps

package bbc_pkg;

  typedef enum logic [1:0] {
    REQ_GET     = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_PIN     = 2'd2,
    REQ_UNPIN   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_UNDER   = 2'd2,
    STAT_OVER    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_MOD
  } state_e;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // One buffer slot as stored in the slot memory.
  typedef struct packed {
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [7:0]  cnt;
    logic [31:0] stamp;
  } entry_t;

  // Outcome of comparing one slot against the request and the best free slot.
  typedef struct packed {
    logic match;
    logic better;
  } cmp_t;

endpackage

[sv/block_buffer_cache_lru.sv]
// Block buffer cache with reference counts and least-recently-released reuse.
// A get scans the slots in order and stops at a tag match or the last slot (early on a hit);
// release/pin/unpin go straight to the modify step. Busy drops in the strobe cycle,
// so a new beat is taken then; one request at a time, and a scan reads one slot per cycle.
// Reset: asynchronous, active low; per-slot flop bits make every slot read as all zero.
// The result strobe lasts one cycle; the receiver cannot stall it.
`timescale 1ns / 1ps

module block_buffer_cache_lru
  import bbc_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  slot_index_i,
  input  logic [31:0] now_tick_i,
  output logic        result_valid_o,
  output logic [4:0]  result_slot_o,
  output logic        hit_o,
  output logic        needs_read_o,
  output logic [1:0]  status_o
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_e state_q, state_d;

  // Latched request beat.
  req_e        req_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  slot_q;
  logic [31:0] now_q;

  // Slot memory plus per-slot flop bits (written, tagged, data valid).
  entry_t                 mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]   ent_ok_q, in_use_q, dvalid_q;
  entry_t                 rdata_q;
  logic                   rd_ok_q, rd_in_use_q, rd_dv_q;
  logic [IDX_W-1:0]       raddr;

  // Memory write port, driven by the output block.
  logic                   mem_we;
  logic [IDX_W-1:0]       waddr;
  entry_t                 wdata;
  logic                   set_tag, set_dv;

  // Scan bookkeeping.
  logic [IDX_W-1:0] addr_q;
  logic             addr_done_q;
  logic             rd_vld_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic             hit_q, have_q;
  logic [IDX_W-1:0] hit_idx_q, best_idx_q;
  entry_t           hit_ent_q;
  logic             hit_dv_q;
  logic [31:0]      best_stamp_q;

  // Result path.
  logic        res_stb;
  logic [4:0]  res_slot;
  logic        res_hit, res_rd;
  status_e     res_status;

  entry_t eff_ent;
  cmp_t   cmp;
  logic   accept, scan_issue, in_range;

  assign accept     = start && (state_q == ST_IDLE);
  assign busy       = (state_q != ST_IDLE);
  assign scan_issue = (state_q == ST_SCAN) && !addr_done_q;
  assign in_range   = 32'(slot_q) < 32'(NUM_SLOTS);

  // Never-written slots read as all zero.
  assign eff_ent = rd_ok_q ? rdata_q : '0;

  // Pick the read address: the addressed slot in the accept cycle, the scan pointer otherwise.
  always_comb begin
    if (accept) begin
      raddr = IDX_W'(slot_index_i);
    end else begin
      raddr = addr_q;
    end
  end

  bbc_slot_cmp u_cmp (
    .ent_i        (eff_ent),
    .in_use_i     (rd_in_use_q),
    .dev_i        (dev_q),
    .blk_i        (blk_q),
    .have_i       (have_q),
    .best_stamp_i (best_stamp_q),
    .res_o        (cmp)
  );

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Per-slot flags are read from the same address and registered alongside the memory read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_ok_q    <= '0;
      in_use_q    <= '0;
      dvalid_q    <= '0;
      rd_ok_q     <= 1'b0;
      rd_in_use_q <= 1'b0;
      rd_dv_q     <= 1'b0;
    end else begin
      rd_ok_q     <= ent_ok_q[raddr];
      rd_in_use_q <= in_use_q[raddr];
      rd_dv_q     <= dvalid_q[raddr];
      if (mem_we) begin
        ent_ok_q[waddr] <= 1'b1;
      end
      if (set_tag) begin
        in_use_q[waddr] <= 1'b1;
      end
      if (set_dv) begin
        dvalid_q[waddr] <= 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_e'(req_type_i) == REQ_GET) ? ST_SCAN : ST_MOD;
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && (cmp.match || (rd_idx_q == LAST_IDX))) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_IDLE;
      ST_MOD:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Memory writes and result values.
  always_comb begin
    mem_we     = 1'b0;
    waddr      = hit_idx_q;
    wdata      = hit_ent_q;
    set_tag    = 1'b0;
    set_dv     = 1'b0;
    res_stb    = 1'b0;
    res_slot   = slot_q;
    res_hit    = 1'b0;
    res_rd     = 1'b0;
    res_status = STAT_OK;
    unique case (state_q)
      ST_UPDATE: begin
        res_stb = 1'b1;
        if (hit_q) begin
          res_slot = 5'(hit_idx_q);
          res_hit  = 1'b1;
          if (hit_ent_q.cnt == COUNT_MAX) begin
            res_status = STAT_OVER;
          end else begin
            mem_we    = 1'b1;
            set_dv    = 1'b1;
            wdata.cnt = hit_ent_q.cnt + 8'd1;
            res_rd    = !hit_dv_q;
          end
        end else if (have_q) begin
          mem_we      = 1'b1;
          set_tag     = 1'b1;
          set_dv      = 1'b1;
          waddr       = best_idx_q;
          wdata.dev   = dev_q;
          wdata.blk   = blk_q;
          wdata.cnt   = 8'd1;
          wdata.stamp = best_stamp_q;
          res_slot    = 5'(best_idx_q);
          res_rd      = 1'b1;
        end else begin
          res_slot   = 5'd0;
          res_status = STAT_NO_FREE;
        end
      end
      ST_MOD: begin
        res_stb = 1'b1;
        waddr   = IDX_W'(slot_q);
        wdata   = eff_ent;
        if (in_range) begin
          if (req_q == REQ_PIN) begin
            if (eff_ent.cnt == COUNT_MAX) begin
              res_status = STAT_OVER;
            end else begin
              mem_we    = 1'b1;
              wdata.cnt = eff_ent.cnt + 8'd1;
            end
          end else if (eff_ent.cnt == 8'd0) begin
            res_status = STAT_UNDER;
          end else begin
            mem_we    = 1'b1;
            wdata.cnt = eff_ent.cnt - 8'd1;
            // Stamp only a release that drops the count to zero.
            if ((req_q == REQ_RELEASE) && (eff_ent.cnt == 8'd1)) begin
              wdata.stamp = now_q;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers, scan pointer and running best.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      addr_q         <= '0;
      addr_done_q    <= 1'b0;
      rd_vld_q       <= 1'b0;
      hit_q          <= 1'b0;
      have_q         <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_vld_q       <= scan_issue;
      result_valid_o <= res_stb;
      if (accept) begin
        addr_q      <= '0;
        addr_done_q <= 1'b0;
        hit_q       <= 1'b0;
        have_q      <= 1'b0;
      end else if (scan_issue) begin
        // Advance the read pointer; hold at the last slot.
        if (addr_q == LAST_IDX) begin
          addr_done_q <= 1'b1;
        end else begin
          addr_q <= addr_q + IDX_W'(1);
        end
      end
      if ((state_q == ST_SCAN) && rd_vld_q) begin
        if (cmp.match) begin
          hit_q <= 1'b1;
        end else if (cmp.better) begin
          have_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (accept) begin
      req_q  <= req_e'(req_type_i);
      dev_q  <= device_i;
      blk_q  <= block_number_i;
      slot_q <= slot_index_i;
      now_q  <= now_tick_i;
    end
    if ((state_q == ST_SCAN) && rd_vld_q) begin
      if (cmp.match) begin
        hit_idx_q <= rd_idx_q;
        hit_ent_q <= eff_ent;
        hit_dv_q  <= rd_dv_q;
      end else if (cmp.better) begin
        best_idx_q   <= rd_idx_q;
        best_stamp_q <= eff_ent.stamp;
      end
    end
    if (res_stb) begin
      result_slot_o <= res_slot;
      hit_o         <= res_hit;
      needs_read_o  <= res_rd;
      status_o      <= res_status;
    end
  end

`ifndef SYNTHESIS
  // Every result beat follows a finishing step of the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == ST_UPDATE || $past(state_q) == ST_MOD))
    else $error("result beat without a finishing step");

  // An accepted beat keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // A disk read is only requested on a successful get.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && needs_read_o) |-> (status_o == STAT_OK))
    else $error("needs_read with a failing status");

  // A hit never reports a missing buffer or an underflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && hit_o) |-> (status_o == STAT_OK || status_o == STAT_OVER))
    else $error("hit with an impossible status");
`endif

endmodule

[sv/bbc_slot_cmp.sv]
// Compare unit of the buffer cache scan: tag match and LRU candidate test.
// Depends on bbc_pkg for the entry and result types.
`timescale 1ns / 1ps

module bbc_slot_cmp
  import bbc_pkg::*;
(
  input  entry_t      ent_i,
  input  logic        in_use_i,
  input  logic [7:0]  dev_i,
  input  logic [31:0] blk_i,
  input  logic        have_i,
  input  logic [31:0] best_stamp_i,
  output cmp_t        res_o
);

  // A slot that was never tagged never matches.
  assign res_o.match  = in_use_i && (ent_i.dev == dev_i) && (ent_i.blk == blk_i);
  // Strict less-than keeps the lowest slot on equal stamps.
  assign res_o.better = (ent_i.cnt == 8'd0) && (!have_i || (ent_i.stamp < best_stamp_i));

endmodule

[verif/bbc_reply_check.sv]
// Reply checker for the block buffer cache: predicts each reply and compares it.
// Watches the start/busy request channel and the result strobe; uses bbc_pkg.
`timescale 1ns / 1ps

module bbc_reply_check
  import bbc_pkg::*;
#(
  parameter int NUM_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  device_i,
  input  logic [31:0] block_number_i,
  input  logic [4:0]  slot_index_i,
  input  logic [31:0] now_tick_i,
  input  logic        res_valid_i,
  input  logic [4:0]  res_slot_i,
  input  logic        res_hit_i,
  input  logic        res_read_i,
  input  logic [1:0]  res_status_i,
  output logic [31:0] err_cnt_o,
  output logic [31:0] pending_o,
  output logic [31:0] hits_o,
  output logic [31:0] misses_o,
  output logic [31:0] no_free_o,
  output logic [31:0] faults_o
);

  localparam int PRINT_CAP = 50;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       need_rd;
    status_e    st;
  } reply_t;

  // Shadow of the slot table.
  logic [7:0]  slot_dev    [NUM_SLOTS];
  logic [31:0] slot_blk    [NUM_SLOTS];
  logic        slot_used   [NUM_SLOTS];
  logic [7:0]  slot_refs   [NUM_SLOTS];
  logic [31:0] slot_stamp  [NUM_SLOTS];
  logic        slot_loaded [NUM_SLOTS];

  reply_t reply_q[$];

  int unsigned n_errors = 0;
  int unsigned n_hits   = 0;
  int unsigned n_misses = 0;
  int unsigned n_nofree = 0;
  int unsigned n_faults = 0;

  assign err_cnt_o = n_errors;
  assign pending_o = reply_q.size();
  assign hits_o    = n_hits;
  assign misses_o  = n_misses;
  assign no_free_o = n_nofree;
  assign faults_o  = n_faults;

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_dev[i]    = '0;
      slot_blk[i]    = '0;
      slot_used[i]   = 1'b0;
      slot_refs[i]   = '0;
      slot_stamp[i]  = '0;
      slot_loaded[i] = 1'b0;
    end
  end

  // Apply one request to the shadow table and return the reply it earns.
  function automatic reply_t next_cache_reply(req_e req, logic [7:0] dev, logic [31:0] blk,
                                              logic [4:0] idx, logic [31:0] tick);
    reply_t r;
    int     best;
    logic   found;
    r.slot    = idx;
    r.hit     = 1'b0;
    r.need_rd = 1'b0;
    r.st      = STAT_OK;
    found     = 1'b0;
    best      = 0;
    if (req == REQ_GET) begin
      // Lowest in-use slot with a matching tag.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!found && slot_used[i] && slot_dev[i] == dev && slot_blk[i] == blk) begin
          found = 1'b1;
          best  = i;
        end
      end
      if (found) begin
        r.slot = 5'(best);
        r.hit  = 1'b1;
        if (slot_refs[best] == COUNT_MAX) begin
          r.st = STAT_OVER;
        end else begin
          slot_refs[best]++;
          r.need_rd         = !slot_loaded[best];
          slot_loaded[best] = 1'b1;
        end
        return r;
      end
      // Oldest free slot; strict compare keeps the lowest on a tie.
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_refs[i] == 0 && (!found || slot_stamp[i] < slot_stamp[best])) begin
          found = 1'b1;
          best  = i;
        end
      end
      if (!found) begin
        r.slot = '0;
        r.st   = STAT_NO_FREE;
      end else begin
        slot_dev[best]    = dev;
        slot_blk[best]    = blk;
        slot_used[best]   = 1'b1;
        slot_refs[best]   = 8'd1;
        slot_loaded[best] = 1'b1;
        r.slot            = 5'(best);
        r.need_rd         = 1'b1;
      end
    end else if (idx < NUM_SLOTS) begin
      if (req == REQ_PIN) begin
        if (slot_refs[idx] == COUNT_MAX) r.st = STAT_OVER;
        else slot_refs[idx]++;
      end else if (slot_refs[idx] == 0) begin
        r.st = STAT_UNDER;
      end else begin
        slot_refs[idx]--;
        if (req == REQ_RELEASE && slot_refs[idx] == 0) slot_stamp[idx] = tick;
      end
    end
    return r;
  endfunction

  task automatic report_error(string msg);
    if (n_errors < PRINT_CAP) $display("%0t bbc_reply_check: %s", $time, msg);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni) begin
      // Retire the reply first: a new request may be taken in the strobe cycle.
      if (res_valid_i) begin
        if (reply_q.size() == 0) begin
          report_error("result strobe with no request outstanding");
        end else begin
          want = reply_q.pop_front();
          if (res_slot_i !== want.slot)
            report_error($sformatf("result_slot: expected %0d, got %0d", want.slot, res_slot_i));
          if (res_hit_i !== want.hit)
            report_error($sformatf("hit: expected %0b, got %0b", want.hit, res_hit_i));
          if (res_read_i !== want.need_rd)
            report_error($sformatf("needs_read: expected %0b, got %0b", want.need_rd,
                                   res_read_i));
          if (res_status_i !== want.st)
            report_error($sformatf("status: expected %s, got %0d", want.st.name(),
                                   res_status_i));
          if (want.st == STAT_NO_FREE) n_nofree++;
          else if (want.st != STAT_OK) n_faults++;
          else if (want.hit) n_hits++;
          else if (want.need_rd) n_misses++;
        end
      end
      if (start_i && !busy_i)
        reply_q.push_back(next_cache_reply(req_e'(req_type_i), device_i, block_number_i,
                                           slot_index_i, now_tick_i));
    end
  end

endmodule

[verif/block_buffer_cache_lru_tb.sv]
// Top of the block buffer cache testbench: clock, reset, request stimulus and verdict.
// Depends on bbc_pkg, block_buffer_cache_lru and the bbc_reply_check module.
`timescale 1ns / 1ps

module block_buffer_cache_lru_tb;
  import bbc_pkg::*;

  localparam int NUM_SLOTS    = 32;
  localparam int POOL_SIZE    = 40;    // more tags than slots, so misses evict
  localparam int RANDOM_ITEMS = 1000;
  localparam int TAIL_CYCLES  = 2 * NUM_SLOTS + 8;
  // A quiet stretch far beyond the longest get scan and the longest sender gap
  // means the block has hung.
  localparam int STALL_LIMIT  = 2000;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic [1:0]  req_type_i     = REQ_GET;
  logic [7:0]  device_i       = '0;
  logic [31:0] block_number_i = '0;
  logic [4:0]  slot_index_i   = '0;
  logic [31:0] now_tick_i     = '0;
  logic        busy;
  logic        result_valid_o;
  logic [4:0]  result_slot_o;
  logic        hit_o;
  logic        needs_read_o;
  logic [1:0]  status_o;

  logic [31:0] n_err, n_pending, n_hits, n_misses, n_nofree, n_faults;

  // Tag pool for repeat gets, and the slots handed out by successful gets.
  logic [7:0]  pool_dev [POOL_SIZE];
  logic [31:0] pool_blk [POOL_SIZE];
  logic [4:0]  held_q[$];

  int unsigned n_req[4] = '{default: 0};
  int unsigned idle_run = 0;
  logic        gaps_on  = 1'b1;

  always #2 clk_i = ~clk_i;

  block_buffer_cache_lru #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .device_i       (device_i),
    .block_number_i (block_number_i),
    .slot_index_i   (slot_index_i),
    .now_tick_i     (now_tick_i),
    .result_valid_o (result_valid_o),
    .result_slot_o  (result_slot_o),
    .hit_o          (hit_o),
    .needs_read_o   (needs_read_o),
    .status_o       (status_o)
  );

  bbc_reply_check #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_type_i     (req_type_i),
    .device_i       (device_i),
    .block_number_i (block_number_i),
    .slot_index_i   (slot_index_i),
    .now_tick_i     (now_tick_i),
    .res_valid_i    (result_valid_o),
    .res_slot_i     (result_slot_o),
    .res_hit_i      (hit_o),
    .res_read_i     (needs_read_o),
    .res_status_i   (status_o),
    .err_cnt_o      (n_err),
    .pending_o      (n_pending),
    .hits_o         (n_hits),
    .misses_o       (n_misses),
    .no_free_o      (n_nofree),
    .faults_o       (n_faults)
  );

  // Remember every slot a get actually took a reference on, so later releases
  // and unpins mostly land on held buffers. Sample mid-cycle to stay clear of
  // the stimulus, which runs just after the rising edge.
  always @(negedge clk_i) begin
    if (result_valid_o && (hit_o || needs_read_o) && status_o == STAT_OK)
      held_q.push_back(result_slot_o);
  end

  // Watchdog: end the run when no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("block_buffer_cache_lru_tb: errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Present one request beat and hold it until the block takes it. Returns at
  // the accepting edge with start still high, so the next beat can follow
  // back to back.
  task automatic send_beat(req_e req, logic [7:0] dev, logic [31:0] blk, logic [4:0] slot,
                           logic [31:0] tick);
    start          <= 1'b1;
    req_type_i     <= req;
    device_i       <= dev;
    block_number_i <= blk;
    slot_index_i   <= slot;
    now_tick_i     <= tick;
    n_req[req]++;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly back to back, often a short gap, now and then a long one.
  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gaps_on) begin
      if (r >= 90) pause($urandom_range(10, 60));
      else if (r >= 55) pause($urandom_range(1, 4));
    end
  endtask

  // Hold the sender off until every outstanding reply has come back.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk_i); while (n_pending != 0);
    @(posedge clk_i);
  endtask

  // Ticks cluster on the extremes and on a few small values to force stamp ties.
  function automatic logic [31:0] pick_tick();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic get_pool();
    int k;
    k = $urandom_range(0, POOL_SIZE - 1);
    send_beat(REQ_GET, pool_dev[k], pool_blk[k], 5'($urandom_range(0, 31)), $urandom);
  endtask

  // Drop a reference on a held slot, or on any slot when none is held.
  task automatic drop_held(req_e req);
    int         k;
    logic [4:0] slot;
    if (held_q.size() == 0) begin
      slot = 5'($urandom_range(0, 31));
    end else begin
      k    = $urandom_range(0, held_q.size() - 1);
      slot = held_q[k];
      held_q.delete(k);
    end
    send_beat(req, 8'($urandom), $urandom, slot, pick_tick());
  endtask

  task automatic pin_any();
    logic [4:0] slot;
    if (held_q.size() != 0 && $urandom_range(0, 1)) begin
      slot = held_q[$urandom_range(0, held_q.size() - 1)];
      held_q.push_back(slot);
    end else begin
      slot = 5'($urandom_range(0, 31));
    end
    send_beat(REQ_PIN, 8'($urandom), $urandom, slot, pick_tick());
  endtask

  // Fill every slot with fresh tags until gets run out of buffers, then give
  // all held references back.
  task automatic fill_and_free();
    repeat (NUM_SLOTS + 4) begin
      send_beat(REQ_GET, 8'($urandom), $urandom, 5'($urandom_range(0, 31)), $urandom);
      random_gap();
    end
    drain();
    while (held_q.size() != 0) begin
      drop_held(REQ_RELEASE);
      random_gap();
    end
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32) get_pool();
    else if (r < 40) send_beat(REQ_GET, 8'($urandom), $urandom,
                               5'($urandom_range(0, 31)), $urandom);
    else if (r < 70) drop_held(REQ_RELEASE);
    else if (r < 76) send_beat(REQ_RELEASE, 8'($urandom), $urandom,
                               5'($urandom_range(0, 31)), pick_tick());
    else if (r < 84) pin_any();
    else if (r < 94) drop_held(REQ_UNPIN);
    else send_beat(REQ_UNPIN, 8'($urandom), $urandom, 5'($urandom_range(0, 31)),
                   pick_tick());
  endtask

  initial begin
    // Pool tags share a device or a block number with their neighbor, so the
    // tag compare must look at both halves.
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_dev[k] = (k % 3 == 1) ? pool_dev[k - 1] : 8'($urandom);
      pool_blk[k] = (k % 3 == 2) ? pool_blk[k - 1] : $urandom;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Reset slots carry tag zero but must not match it.
    send_beat(REQ_GET, 8'h00, 32'h0, 5'h1F, 32'hFFFF_FFFF);         // miss, slot 0
    random_gap();
    send_beat(REQ_GET, 8'h00, 32'h0, 5'h00, 32'h0);                 // hit, slot 0
    random_gap();
    send_beat(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 5'h00, 32'h0);         // miss, slot 1
    random_gap();
    send_beat(REQ_RELEASE, 8'h00, 32'h0, 5'd1, 32'hFFFF_FFFF);      // to zero, newest stamp
    random_gap();
    send_beat(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 5'd9, 32'h0);          // hit on a free slot
    random_gap();
    send_beat(REQ_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'hFFFF_FFFF);
    random_gap();
    send_beat(REQ_UNPIN, 8'h00, 32'h0, 5'd5, 32'h0);                // underflow
    send_beat(REQ_RELEASE, 8'h00, 32'h0, 5'd6, 32'h1234);           // underflow
    send_beat(REQ_PIN, 8'h00, 32'h0, 5'd7, 32'h0);                  // pin a slot never used
    send_beat(REQ_UNPIN, 8'h00, 32'h0, 5'd7, 32'hFFFF_FFFF);        // to zero, no stamp
    random_gap();
    send_beat(REQ_GET, 8'h01, 32'h1, 5'h1F, 32'h0);                 // lowest zero stamp: 2
    send_beat(REQ_GET, 8'h00, 32'h1, 5'h00, 32'h0);                 // same device, miss
    send_beat(REQ_GET, 8'h01, 32'h0, 5'h00, 32'h0);                 // same block, miss
    random_gap();
    send_beat(REQ_RELEASE, 8'h00, 32'h0, 5'd31, 32'h0);             // underflow, top slot
    send_beat(REQ_PIN, 8'h00, 32'h0, 5'd31, 32'h0);
    send_beat(REQ_RELEASE, 8'h00, 32'h0, 5'd31, 32'h1);             // stamp 1
    send_beat(REQ_GET, 8'h00, 32'h0, 5'h00, 32'h0);                 // slot 0 at three
    send_beat(REQ_RELEASE, 8'h00, 32'h0, 5'd0, 32'h5);              // back to two, no stamp
    drain();

    // Pin slot 0 up to the count ceiling with no gaps, then push past it by pin
    // and by a hit. Slot 0 stays heavily pinned for the rest of the run.
    repeat (253) send_beat(REQ_PIN, 8'($urandom), $urandom, 5'd0, $urandom);
    send_beat(REQ_PIN, 8'h00, 32'h0, 5'd0, 32'h0);                  // overflow
    send_beat(REQ_GET, 8'h00, 32'h0, 5'd3, 32'h0);                  // hit at full count
    random_gap();

    // Random part: idling switches on and off in stretches of a hundred beats,
    // and twice the table is filled to exhaustion and emptied again.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (n == 300 || n == 700) fill_and_free();
      random_item();
      random_gap();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d gets, %0d releases, %0d pins, %0d unpins",
             n_req[REQ_GET], n_req[REQ_RELEASE], n_req[REQ_PIN], n_req[REQ_UNPIN]);
    $display("replies: %0d hits, %0d misses, %0d with no free buffer, %0d count faults",
             n_hits, n_misses, n_nofree, n_faults);
    if (n_err == 0 && n_pending == 0) begin
      $display("block_buffer_cache_lru_tb: clean");
    end else begin
      $display("block_buffer_cache_lru_tb: errors");
    end
    $finish;
  end

endmodule
